// ===== rtl/core/led_matrix_scan_with_overlay_assert.svh =====
// assertion macros for the led matrix scan block
// include guard keeps a second include harmless
`ifndef LED_MATRIX_SCAN_WITH_OVERLAY_ASSERT_SVH
`define LED_MATRIX_SCAN_WITH_OVERLAY_ASSERT_SVH

// antecedent holds, consequent must hold in the same cycle
`define LMSO_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds, consequent must hold in the next cycle
`define LMSO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lmso_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmso_pkg
// shared constants, types and helpers for the led matrix row scan block
// ----------------------------------------------------------------------------
package lmso_pkg;

    localparam int ROWS           = 8;
    localparam int TICKS_PER_UNIT = 100;

    localparam int ROW_W      = $clog2(ROWS);
    localparam int FRAME_W    = 64;
    localparam int BYTE_W     = 8;
    localparam int UNITS_W    = 8;
    localparam int COUNT_W    = 15;
    localparam int FRAME_ROWS = 8;
    localparam int PROD_W     = UNITS_W + $clog2(TICKS_PER_UNIT + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [BYTE_W-1:0]  ROW_BIT0  = 8'h80;

    // request codes
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_PRIMARY = 2'd1;
    localparam logic [1:0] REQ_OVERLAY = 2'd2;

    // frame memory entries
    localparam logic FRAME_PRIMARY = 1'b0;
    localparam logic FRAME_OVERLAY = 1'b1;

    // tick in flight between the scan control and the output stage
    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
        logic             ov;
    } scan_tick_t;

    // column byte of one row, rows past the stored eight read as zero
    function automatic logic [BYTE_W-1:0] row_byte(input logic [FRAME_W-1:0] f,
                                                   input logic [ROW_W-1:0] r);
        logic [5:0] idx;
        idx = {3'(r), 3'b000};
        if (int'(r) < FRAME_ROWS)
            row_byte = f[idx +: BYTE_W];
        else
            row_byte = '0;
    endfunction

    // active-low one-hot row drive, bit 7 is row 0
    function automatic logic [BYTE_W-1:0] row_drive(input logic [ROW_W-1:0] r);
        logic [BYTE_W-1:0] sel;
        if (int'(r) < FRAME_ROWS)
            sel = ROW_BIT0 >> 3'(r);
        else
            sel = '0;
        row_drive = ~sel;
    endfunction

endpackage

// ===== rtl/core/lmso_frame_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmso_frame_mem
// two-entry frame store, one 64-bit frame per entry, registered read
// ----------------------------------------------------------------------------
module lmso_frame_mem
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic                          wr_sel,
    input  logic [lmso_pkg::FRAME_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic                          rd_sel,
    output logic [lmso_pkg::FRAME_W-1:0]  rd_data
);
    import lmso_pkg::*;

    logic [FRAME_W-1:0] mem [0:1];
    logic [FRAME_W-1:0] rdata_reg;
    logic [1:0]         written_reg;
    logic [1:0]         written_next;
    logic               rvalid_reg;
    logic               rvalid_next;

    // frame storage, read before write on the same edge
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_sel] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_sel];
    end

    always_comb
    begin
        written_next = written_reg;
        if (wr_en)
            written_next[wr_sel] = 1'b1;
        rvalid_next = rvalid_reg;
        if (rd_en)
            rvalid_next = written_reg[rd_sel];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            written_reg <= written_next;
            rvalid_reg  <= rvalid_next;
        end
    end

    // an entry never loaded reads as the all-zero reset frame
    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== rtl/core/lmso_scan_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmso_scan_ctrl
// request decode, row counter, overlay countdown and memory access control
// ----------------------------------------------------------------------------
module lmso_scan_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [1:0]                     req_type,
    input  logic [lmso_pkg::UNITS_W-1:0]   overlay_units,
    input  logic                           s1_adv,
    output logic                           wr_en,
    output logic                           wr_sel,
    output logic                           rd_en,
    output logic                           rd_sel,
    output lmso_pkg::scan_tick_t           tick
);
    import lmso_pkg::*;

    logic [COUNT_W-1:0] countdown_reg;
    logic [COUNT_W-1:0] countdown_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    scan_tick_t         tick_reg;
    scan_tick_t         tick_next;
    logic               ov_now;
    logic               is_tick;
    logic [PROD_W-1:0]  ticks;
    logic [COUNT_W-1:0] load_count;

    assign ov_now = (countdown_reg != '0);
    assign ticks  = PROD_W'(overlay_units) * PROD_W'(TICKS_PER_UNIT);

    // saturate the armed countdown
    assign load_count = (ticks > PROD_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(ticks);

    always_comb
    begin
        wr_en          = 1'b0;
        wr_sel         = FRAME_PRIMARY;
        is_tick        = 1'b0;
        countdown_next = countdown_reg;
        row_next       = row_reg;
        unique case (req_type)
            REQ_TICK:
            begin
                is_tick = accept;
                if (accept)
                begin
                    if (ov_now)
                        countdown_next = countdown_reg - 1'b1;
                    if (row_reg == ROW_W'(ROWS - 1))
                        row_next = '0;
                    else
                        row_next = row_reg + 1'b1;
                end
            end
            REQ_PRIMARY:
            begin
                wr_en  = accept;
                wr_sel = FRAME_PRIMARY;
            end
            REQ_OVERLAY:
            begin
                wr_en  = accept;
                wr_sel = FRAME_OVERLAY;
                if (accept)
                    countdown_next = load_count;
            end
            default:
            begin
            end
        endcase
    end

    assign rd_en  = is_tick;
    assign rd_sel = ov_now ? FRAME_OVERLAY : FRAME_PRIMARY;

    // stage loads when it is empty or its tick moves on to the output register
    always_comb
    begin
        tick_next = tick_reg;
        if (s1_adv || !tick_reg.valid)
        begin
            tick_next.valid = is_tick;
            tick_next.row   = row_reg;
            tick_next.ov    = ov_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_reg <= '0;
            row_reg       <= '0;
            tick_reg      <= '0;
        end
        else
        begin
            countdown_reg <= countdown_next;
            row_reg       <= row_next;
            tick_reg      <= tick_next;
        end
    end

    assign tick = tick_reg;

endmodule

// ===== rtl/core/led_matrix_scan_with_overlay.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_scan_with_overlay
// row-scan driver for an 8x8 led matrix with a primary and a timed overlay frame
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall carry req_type, frame_bits, overlay_units;
//   a transfer happens when in_valid is high and in_stall is low
// req_type tick gives one output transfer; primary and overlay loads give none,
//   overlay load arms a countdown of overlay_units * 100 ticks
// output channel: out_valid / out_stall carry row_select (active low, bit 7 is
//   row 0), column_bits and overlay_shown
// path: a tick goes through the frame memory read register, then the output
//   register, before it shows at the output
// throughput: one item every cycle while in_stall is low;
//   a load may directly follow a tick and the reverse
// reset: both frames read as zero, countdown and row go to zero, no output
// stall: while out_stall holds a full output register and a tick waits behind
//   it, in_stall rises; the output payload holds until it is taken
// ----------------------------------------------------------------------------
module led_matrix_scan_with_overlay
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic [lmso_pkg::FRAME_W-1:0]  frame_bits,
    input  logic [lmso_pkg::UNITS_W-1:0]  overlay_units,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lmso_pkg::BYTE_W-1:0]   row_select,
    output logic [lmso_pkg::BYTE_W-1:0]   column_bits,
    output logic                          overlay_shown
);
    import lmso_pkg::*;

    logic               accept;
    logic               s1_adv;
    logic               wr_en;
    logic               wr_sel;
    logic               rd_en;
    logic               rd_sel;
    logic [FRAME_W-1:0] rd_data;
    scan_tick_t         tick;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [BYTE_W-1:0]  row_select_reg;
    logic [BYTE_W-1:0]  row_select_next;
    logic [BYTE_W-1:0]  column_bits_reg;
    logic [BYTE_W-1:0]  column_bits_next;
    logic               overlay_shown_reg;
    logic               overlay_shown_next;

    // read stage moves on whenever the output register is free or draining
    assign s1_adv   = !out_valid_reg || !out_stall;
    assign in_stall = tick.valid && !s1_adv;
    assign accept   = in_valid && !in_stall;

    lmso_scan_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .req_type      (req_type),
        .overlay_units (overlay_units),
        .s1_adv        (s1_adv),
        .wr_en         (wr_en),
        .wr_sel        (wr_sel),
        .rd_en         (rd_en),
        .rd_sel        (rd_sel),
        .tick          (tick)
    );

    // the read address is the frame chosen by the countdown at transfer time
    lmso_frame_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_sel  (wr_sel),
        .wr_data (frame_bits),
        .rd_en   (rd_en),
        .rd_sel  (rd_sel),
        .rd_data (rd_data)
    );

    // output register, loaded from the read stage
    always_comb
    begin
        out_valid_next     = out_valid_reg;
        row_select_next    = row_select_reg;
        column_bits_next   = column_bits_reg;
        overlay_shown_next = overlay_shown_reg;
        if (s1_adv)
        begin
            out_valid_next = tick.valid;
            if (tick.valid)
            begin
                row_select_next    = row_drive(tick.row);
                column_bits_next   = row_byte(rd_data, tick.row);
                overlay_shown_next = tick.ov;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        row_select_reg    <= row_select_next;
        column_bits_reg   <= column_bits_next;
        overlay_shown_reg <= overlay_shown_next;
    end

    assign out_valid     = out_valid_reg;
    assign row_select    = row_select_reg;
    assign column_bits   = column_bits_reg;
    assign overlay_shown = overlay_shown_reg;

endmodule

// ===== rtl/core/lmso_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmso_checker
// port-level checks for the led matrix scan block
// ----------------------------------------------------------------------------
`include "led_matrix_scan_with_overlay_assert.svh"

module lmso_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [lmso_pkg::BYTE_W-1:0]   row_select,
    input  logic [lmso_pkg::BYTE_W-1:0]   column_bits,
    input  logic                          overlay_shown
);
    import lmso_pkg::*;

    // exactly one row line driven low on every shown row
    `LMSO_ASSERT_SAME(a_row_onehot, clk, rst_n, out_valid, $onehot(~row_select), "row select not one-hot low")

    // input backs up only behind a full, stalled output
    `LMSO_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without output backpressure")

    // a stalled result stays put
    `LMSO_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(row_select) && $stable(column_bits) && $stable(overlay_shown), "stalled output changed")

    // stall on the input is never asserted while the input idles and output is empty
    `LMSO_ASSERT_SAME(a_no_idle_stall, clk, rst_n, !in_valid && !out_valid, !in_stall, "input stalled with empty output")

endmodule

bind led_matrix_scan_with_overlay lmso_checker u_lmso_checker (.*);

// ===== bench/tb_led_matrix_scan_with_overlay.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_matrix_scan_with_overlay
// self-checking bench for the led matrix row scan with timed overlay
// ----------------------------------------------------------------------------
// a scoreboard class keeps its own copy of both frames, the overlay countdown
// and the scan row, predicts one row view per accepted tick and compares every
// output transfer against the oldest prediction; a short directed sequence is
// followed by random runs, each opened by an overlay load, with random idling
// on both channels and one long receiver hold-off that backs up the input
// ----------------------------------------------------------------------------
module tb_led_matrix_scan_with_overlay;

    import lmso_pkg::*;

    // request code the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 700;
    // idling stops once this many random items are in
    localparam int CALM_AFTER   = 620;
    // receiver hold-off: start point and length in cycles after reset
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 80;
    // margin after the last expected row has been checked
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    // one row as the matrix sees it
    typedef struct packed {
        logic [BYTE_W-1:0] row_select;
        logic [BYTE_W-1:0] column_bits;
        logic              overlay_shown;
    } row_view_t;

    // predicts the row views and checks the output transfers against them
    class row_scan_board;
        logic [BYTE_W-1:0] primary_rows [ROWS];
        logic [BYTE_W-1:0] overlay_rows [ROWS];
        int unsigned       overlay_left;
        int unsigned       scan_row;
        row_view_t         expected_rows [$];
        int                errors;

        function new();
            foreach (primary_rows[i])
            begin
                primary_rows[i] = '0;
                overlay_rows[i] = '0;
            end
            overlay_left = 0;
            scan_row     = 0;
            errors       = 0;
        endfunction

        // accepted input transfer
        function void note_request(input logic [1:0]         req,
                                   input logic [FRAME_W-1:0] bits,
                                   input logic [UNITS_W-1:0] units);
            row_view_t         view;
            logic [BYTE_W-1:0] row_byte_v;
            int unsigned       ticks;
            case (req) inside
                REQ_PRIMARY, REQ_OVERLAY:
                begin
                    // full frame write, rows past the eighth load as zero
                    for (int i = 0; i < ROWS; i++)
                    begin
                        row_byte_v = (i < FRAME_ROWS) ? bits[8*i +: 8] : '0;
                        if (req == REQ_PRIMARY)
                            primary_rows[i] = row_byte_v;
                        else
                            overlay_rows[i] = row_byte_v;
                    end
                    if (req == REQ_OVERLAY)
                    begin
                        ticks        = units * TICKS_PER_UNIT;
                        overlay_left = (ticks > COUNT_MAX) ? COUNT_MAX : ticks;
                    end
                end
                REQ_TICK:
                begin
                    view.overlay_shown = (overlay_left != 0);
                    view.row_select    = (scan_row < FRAME_ROWS) ?
                                         ~(ROW_BIT0 >> scan_row) : 8'hFF;
                    view.column_bits   = view.overlay_shown ?
                                         overlay_rows[scan_row] : primary_rows[scan_row];
                    expected_rows.push_back(view);
                    if (view.overlay_shown)
                        overlay_left--;
                    scan_row = (scan_row + 1) % ROWS;
                end
                default:
                begin
                    // unused code, no state change and no row
                end
            endcase
        endfunction

        // accepted output transfer
        function void check_row(input logic [BYTE_W-1:0] sel,
                                input logic [BYTE_W-1:0] cols,
                                input logic              shown);
            row_view_t want;
            if (expected_rows.size() == 0)
            begin
                $error("row transfer with no tick waiting: row_select %h column_bits %h",
                       sel, cols);
                errors++;
                return;
            end
            want = expected_rows.pop_front();
            if (sel !== want.row_select)
            begin
                $error("row_select: expected %h, actual %h", want.row_select, sel);
                errors++;
            end
            if (cols !== want.column_bits)
            begin
                $error("column_bits: expected %h, actual %h", want.column_bits, cols);
                errors++;
            end
            if (shown !== want.overlay_shown)
            begin
                $error("overlay_shown: expected %b, actual %b", want.overlay_shown, shown);
                errors++;
            end
        endfunction
    endclass

    // every block input has a known value from time zero
    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic [1:0]         req_type      = REQ_TICK;
    logic [FRAME_W-1:0] frame_bits    = '0;
    logic [UNITS_W-1:0] overlay_units = '0;
    logic               out_valid;
    logic               out_stall     = 1'b0;
    logic [BYTE_W-1:0]  row_select;
    logic [BYTE_W-1:0]  column_bits;
    logic               overlay_shown;

    // set near the end of the run, turns idling off on both sides
    bit                 calm = 1'b0;
    int                 cycle_count = 0;
    row_scan_board      board;

    led_matrix_scan_with_overlay u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .frame_bits    (frame_bits),
        .overlay_units (overlay_units),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .row_select    (row_select),
        .column_bits   (column_bits),
        .overlay_shown (overlay_shown)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit, far above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // monitors sample at the edge, before the nonblocking updates land,
    // so both sides see the values that decided the transfer
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_request(req_type, frame_bits, overlay_units);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_row(row_select, column_bits, overlay_shown);
    end

    // receiver: random stall bursts, one long hold-off counted here so that
    // the output register and the tick behind it fill and in_stall rises
    initial
    begin
        int  rx_cycles;
        int  burst;
        bit  held;
        rx_cycles = 0;
        held      = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            if (!held && rx_cycles >= HOLD_AT)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_cycles += HOLD_CYCLES;
                out_stall <= 1'b0;
            end
            else if (calm)
                out_stall <= 1'b0;
            else if ($urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 7);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                rx_cycles += burst;
                out_stall <= 1'b0;
            end
        end
    end

    // offer one item and hold it until the transfer, then maybe go idle;
    // valid stays high between back-to-back items
    task automatic offer(input logic [1:0]         req,
                         input logic [FRAME_W-1:0] bits,
                         input logic [UNITS_W-1:0] units);
        in_valid      <= 1'b1;
        req_type      <= req;
        frame_bits    <= bits;
        overlay_units <= units;
        do
            @(posedge clk);
        while (in_stall);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // stimulus
    initial
    begin
        int                 done_items;
        int                 run_len;
        int                 pick;
        logic [UNITS_W-1:0] units;
        logic [FRAME_W-1:0] bits;

        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset view, ignored code, frame extremes, zero-length
        // overlay, short and longest overlay, primary write under overlay
        offer(REQ_TICK,    '0, '0);
        offer(REQ_UNUSED,  '1, '1);
        offer(REQ_TICK,    '1, '1);
        offer(REQ_PRIMARY, '1, '0);
        offer(REQ_TICK,    '0, '0);
        offer(REQ_TICK,    '0, '0);
        offer(REQ_PRIMARY, 64'h0123_4567_89AB_CDEF, '1);
        offer(REQ_TICK,    '0, '0);
        offer(REQ_TICK,    '0, '0);
        offer(REQ_OVERLAY, '1, 8'd0);
        offer(REQ_TICK,    '0, '0);
        offer(REQ_OVERLAY, 64'hA5A5_5A5A_0F0F_F0F0, 8'd1);
        offer(REQ_TICK,    '0, '0);
        offer(REQ_TICK,    '1, '1);
        offer(REQ_OVERLAY, 64'hFEDC_BA98_7654_3210, 8'd255);
        offer(REQ_TICK,    '0, '0);
        offer(REQ_PRIMARY, '0, 8'hAA);
        offer(REQ_TICK,    '0, '0);
        offer(REQ_OVERLAY, '0, 8'h00);
        offer(REQ_TICK,    '0, '0);
        offer(REQ_UNUSED,  64'h5555_5555_5555_5555, 8'h55);
        offer(REQ_TICK,    '0, '0);
        offer(REQ_TICK,    '0, '0);

        // random runs: each opens with an overlay load, mostly short ones so
        // that runs past a hundred ticks see the countdown expire
        done_items = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                units = 8'($urandom_range(3, 255));
            else
                units = 8'($urandom_range(0, 2));
            offer(REQ_OVERLAY, {$urandom(), $urandom()}, units);
            done_items++;
            run_len = $urandom_range(1, 160);
            for (int k = 0; k < run_len && done_items < RANDOM_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                bits = (pick == 95) ? '1 : {$urandom(), $urandom()};
                if (pick < 88)
                begin
                    // payload is noise on a tick
                    offer(REQ_TICK, bits, 8'($urandom()));
                    done_items++;
                end
                else if (pick < 96)
                begin
                    offer(REQ_PRIMARY, bits, 8'($urandom()));
                    done_items++;
                end
                else
                    offer(REQ_UNUSED, bits, 8'($urandom()));
                calm = (done_items >= CALM_AFTER);
            end
        end

        in_valid <= 1'b0;
        while (board.expected_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0 && board.expected_rows.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lmso_pkg.sv
rtl/core/lmso_frame_mem.sv
rtl/core/lmso_scan_ctrl.sv
rtl/core/led_matrix_scan_with_overlay.sv
rtl/core/lmso_checker.sv
bench/tb_led_matrix_scan_with_overlay.sv
